// ----- hdl/crp_pkg.sv -----
// Shared codes and types for the clock page replacement table.
`timescale 1ns / 1ps

package crp_pkg;

  typedef logic [1:0] kind_t;
  typedef logic [1:0] status_t;

  localparam kind_t KIND_INSERT = 2'd0;
  localparam kind_t KIND_REMOVE = 2'd1;
  localparam kind_t KIND_EVICT  = 2'd2;
  localparam kind_t KIND_ACCESS = 2'd3;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_NOT_FOUND = 2'd1;
  localparam status_t ST_EMPTY     = 2'd2;
  localparam status_t ST_FULL      = 2'd3;

  typedef struct packed {
    logic entry;
    logic link;
  } store_wr_t;

endpackage

// ----- hdl/crp_item_if.sv -----
// Input item channel: valid/ready handshake with request payload.
`timescale 1ns / 1ps

interface crp_item_if #(
  parameter int PAGE_BITS  = 20,
  parameter int FRAME_BITS = 8
);
  import crp_pkg::*;

  logic                  valid;
  logic                  ready;
  kind_t                 kind;
  logic [PAGE_BITS-1:0]  page_number;
  logic [FRAME_BITS-1:0] frame;
  logic                  referenced_in;
  logic                  modified_in;

  modport source (
    output valid, kind, page_number, frame, referenced_in, modified_in,
    input  ready
  );

  modport sink (
    input  valid, kind, page_number, frame, referenced_in, modified_in,
    output ready
  );
endinterface

// ----- hdl/crp_result_if.sv -----
// Result item channel: valid/ready handshake with result payload.
`timescale 1ns / 1ps

interface crp_result_if #(
  parameter int PAGE_BITS  = 20,
  parameter int FRAME_BITS = 8,
  parameter int COUNT_BITS = 7
);
  import crp_pkg::*;

  logic                  valid;
  logic                  ready;
  status_t               status;
  logic [PAGE_BITS-1:0]  victim_page;
  logic [FRAME_BITS-1:0] victim_frame;
  logic                  writeback;
  logic [COUNT_BITS-1:0] mapped_count;

  modport source (
    output valid, status, victim_page, victim_frame, writeback, mapped_count,
    input  ready
  );

  modport sink (
    input  valid, status, victim_page, victim_frame, writeback, mapped_count,
    output ready
  );
endinterface

// ----- hdl/crp_store.sv -----
// Slot memories: page number, frame number and next link, registered read.
`timescale 1ns / 1ps

module crp_store #(
  parameter int ENTRIES    = 64,
  parameter int PAGE_BITS  = 20,
  parameter int FRAME_BITS = 8,
  parameter int SLOT_BITS  = 6
) (
  input  logic                  clk,
  input  crp_pkg::store_wr_t    wr,
  input  logic [SLOT_BITS-1:0]  waddr,
  input  logic [PAGE_BITS-1:0]  wpage,
  input  logic [FRAME_BITS-1:0] wframe,
  input  logic [SLOT_BITS-1:0]  wlink,
  input  logic [SLOT_BITS-1:0]  raddr,
  output logic [PAGE_BITS-1:0]  rpage,
  output logic [FRAME_BITS-1:0] rframe,
  output logic [SLOT_BITS-1:0]  rlink
);
  import crp_pkg::*;

  logic [PAGE_BITS-1:0]  page_mem  [ENTRIES];
  logic [FRAME_BITS-1:0] frame_mem [ENTRIES];
  logic [SLOT_BITS-1:0]  link_mem  [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr.entry) begin
      page_mem[waddr]  <= wpage;
      frame_mem[waddr] <= wframe;
    end
    if (wr.link) begin
      link_mem[waddr] <= wlink;
    end
    rpage  <= page_mem[raddr];
    rframe <= frame_mem[raddr];
    rlink  <= link_mem[raddr];
  end

endmodule

// ----- hdl/clock_page_replacement.sv -----
// Clock (second chance) page replacement table, top level.
//
// Usage:
//   in_item carries one request (insert, remove by page, evict, access);
//   out_result returns exactly one result item per request. Both channels
//   move an item on a clock edge with valid and ready high.
//   Entries live in a circular linked list held in slot memories; the walk
//   follows one link per cycle through a registered memory read.
// The work per item sets how long it takes: insert grows with the index of the
//   lowest free slot (an insert into a full table skips the scan), remove/access
//   with the position of the match, and evict with the entries passed while
//   clearing referenced bits, at most the occupancy of the table.
//   The free-slot scan and the link walk through the memory read port set this.
//   One item is in work at a time; in_item.ready is high only when idle.
// Reset: rst (synchronous) empties the table, no clearing pass needed.
// Stall: a finished result sits in the output register; the next item is
//   accepted meanwhile, and its result waits until the register is free.
`timescale 1ns / 1ps

module clock_page_replacement #(
  parameter int ENTRIES    = 64,
  parameter int PAGE_BITS  = 20,
  parameter int FRAME_BITS = 8
) (
  input  logic         clk,
  input  logic         rst,
  crp_item_if.sink     in_item,
  crp_result_if.source out_result
);
  import crp_pkg::*;

  localparam int SLOT_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int COUNT_BITS = $clog2(ENTRIES + 1);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_START    = 3'd1;
  localparam logic [2:0] S_SCAN     = 3'd2;
  localparam logic [2:0] S_INS_LINK = 3'd3;
  localparam logic [2:0] S_WALK     = 3'd4;
  localparam logic [2:0] S_RESULT   = 3'd5;

  logic [2:0]            state;
  kind_t                 kind_q;
  logic [PAGE_BITS-1:0]  pg_q;
  logic [FRAME_BITS-1:0] frm_q;
  logic                  refin_q;
  logic                  modin_q;

  logic [SLOT_BITS-1:0]  tail;
  logic [COUNT_BITS-1:0] occ;
  logic [COUNT_BITS-1:0] cnt;
  logic [SLOT_BITS-1:0]  cur;
  logic [SLOT_BITS-1:0]  prev;
  logic [SLOT_BITS-1:0]  idx;
  logic [SLOT_BITS-1:0]  head_hold;
  logic [ENTRIES-1:0]    valid_v;
  logic [ENTRIES-1:0]    ref_v;
  logic [ENTRIES-1:0]    dirty_v;

  status_t               res_status;
  logic [PAGE_BITS-1:0]  res_page;
  logic [FRAME_BITS-1:0] res_frame;
  logic                  res_wb;

  logic                  o_valid;
  status_t               o_status;
  logic [PAGE_BITS-1:0]  o_page;
  logic [FRAME_BITS-1:0] o_frame;
  logic                  o_wb;
  logic [COUNT_BITS-1:0] o_count;

  store_wr_t             wr;
  logic [SLOT_BITS-1:0]  waddr;
  logic [SLOT_BITS-1:0]  wlink;
  logic [SLOT_BITS-1:0]  raddr;
  logic [PAGE_BITS-1:0]  rpage;
  logic [FRAME_BITS-1:0] rframe;
  logic [SLOT_BITS-1:0]  rlink;

  logic                  hit;
  logic                  out_free;
  logic [COUNT_BITS-1:0] occ_dec;

  crp_store #(
    .ENTRIES    (ENTRIES),
    .PAGE_BITS  (PAGE_BITS),
    .FRAME_BITS (FRAME_BITS),
    .SLOT_BITS  (SLOT_BITS)
  ) u_store (
    .clk    (clk),
    .wr     (wr),
    .waddr  (waddr),
    .wpage  (pg_q),
    .wframe (frm_q),
    .wlink  (wlink),
    .raddr  (raddr),
    .rpage  (rpage),
    .rframe (rframe),
    .rlink  (rlink)
  );

  assign in_item.ready = (state == S_IDLE) && !rst;
  assign out_free      = !o_valid || out_result.ready;
  assign occ_dec       = occ - 1'b1;

  assign out_result.valid        = o_valid;
  assign out_result.status       = o_status;
  assign out_result.victim_page  = o_page;
  assign out_result.victim_frame = o_frame;
  assign out_result.writeback    = o_wb;
  assign out_result.mapped_count = o_count;

  always_comb begin
    raddr = (state == S_START || state == S_WALK) ? rlink : tail;
    if (kind_q == KIND_EVICT) begin
      hit = !ref_v[cur];
    end else begin
      hit = valid_v[cur] && (rpage == pg_q);
    end
    wr    = '0;
    waddr = tail;
    wlink = idx;
    case (state)
      S_SCAN: begin
        if (!valid_v[idx]) begin
          wr.entry = 1'b1;
          wr.link  = 1'b1;
          waddr    = idx;
          wlink    = (occ == '0) ? idx : head_hold;
        end
      end
      S_INS_LINK: begin
        wr.link = 1'b1;
        waddr   = tail;
        wlink   = idx;
      end
      S_WALK: begin
        if (hit && kind_q != KIND_ACCESS) begin
          wr.link = 1'b1;
          waddr   = prev;
          wlink   = rlink;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      tail    <= '0;
      occ     <= '0;
      valid_v <= '0;
      ref_v   <= '0;
      dirty_v <= '0;
      o_valid <= 1'b0;
    end else begin
      if (state == S_RESULT && out_free) begin
        o_valid <= 1'b1;
      end else if (out_result.ready) begin
        o_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_item.valid) begin
            kind_q  <= in_item.kind;
            pg_q    <= in_item.page_number;
            frm_q   <= in_item.frame;
            refin_q <= in_item.referenced_in;
            modin_q <= in_item.modified_in;
            state   <= S_START;
          end
        end
        S_START: begin
          res_page   <= '0;
          res_frame  <= '0;
          res_wb     <= 1'b0;
          cur        <= rlink;
          prev       <= tail;
          cnt        <= '0;
          idx        <= '0;
          head_hold  <= rlink;
          if (kind_q == KIND_INSERT) begin
            if (occ == COUNT_BITS'(ENTRIES)) begin
              res_status <= ST_FULL;
              state      <= S_RESULT;
            end else begin
              res_status <= ST_OK;
              state      <= S_SCAN;
            end
          end else if (occ == '0) begin
            res_status <= (kind_q == KIND_EVICT) ? ST_EMPTY : ST_NOT_FOUND;
            state      <= S_RESULT;
          end else begin
            res_status <= ST_OK;
            state      <= S_WALK;
          end
        end
        S_SCAN: begin
          if (!valid_v[idx]) begin
            valid_v[idx] <= 1'b1;
            ref_v[idx]   <= refin_q;
            dirty_v[idx] <= modin_q;
            occ          <= occ + 1'b1;
            if (occ == '0) begin
              tail  <= idx;
              state <= S_RESULT;
            end else begin
              state <= S_INS_LINK;
            end
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_INS_LINK: begin
          tail  <= idx;
          state <= S_RESULT;
        end
        S_WALK: begin
          if (hit) begin
            if (kind_q == KIND_ACCESS) begin
              ref_v[cur] <= 1'b1;
              if (modin_q) begin
                dirty_v[cur] <= 1'b1;
              end
            end else begin
              res_page     <= rpage;
              res_frame    <= rframe;
              res_wb       <= dirty_v[cur];
              valid_v[cur] <= 1'b0;
              ref_v[cur]   <= 1'b0;
              dirty_v[cur] <= 1'b0;
              occ          <= occ_dec;
              if (occ_dec == '0) begin
                tail <= '0;
              end else if (cur == tail) begin
                tail <= prev;
              end
            end
            state <= S_RESULT;
          end else begin
            if (kind_q == KIND_EVICT) begin
              ref_v[cur] <= 1'b0;
            end
            if (kind_q != KIND_EVICT && cnt == occ_dec) begin
              res_status <= ST_NOT_FOUND;
              state      <= S_RESULT;
            end else begin
              cur  <= rlink;
              prev <= cur;
              cnt  <= cnt + 1'b1;
            end
          end
        end
        S_RESULT: begin
          if (out_free) begin
            o_status <= res_status;
            o_page   <= res_page;
            o_frame  <= res_frame;
            o_wb     <= res_wb;
            o_count  <= occ;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_occ_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_v) == int'(occ))
    else $error("occupancy disagrees with valid slot count");

  a_empty_tail_zero: assert property (@(posedge clk) disable iff (rst)
    occ == '0 |-> tail == '0)
    else $error("tail not zero on empty table");

  a_tail_valid: assert property (@(posedge clk) disable iff (rst)
    occ != '0 |-> valid_v[tail])
    else $error("tail slot not valid");

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= COUNT_BITS'(ENTRIES))
    else $error("occupancy above table size");

  a_walk_exit: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK |=> state == S_WALK || state == S_RESULT)
    else $error("walk left to an unexpected state");

endmodule
